/* hdl/md5_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 package
// Round constants, rotation amounts, initial chaining values and FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned COUNT_W = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } md5_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

/* hdl/md5_digest_engine_unit.sv */
// ----------------------------------------------------------------------------
// MD5 digest engine
// Byte-serial MD5: gathers 64-byte blocks, one shared round unit, digest out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes one message byte per transaction while idle; the input stalls
// otherwise. A byte completing a 64-byte block starts the rounds and then
// the fold step in the single shared round datapath. A last transaction
// pads the block (the 0x80 byte, then a pad sweep writing zero and length
// bytes one at a time, then the start of the rounds), runs one or two final
// compressions, then presents the four digest words, word 0 first. No
// clearing pass is needed after reset.
module md5_digest_engine_unit
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        has_byte,
  input  logic [7:0]  message_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  md5_state_t state, state_next;

  // block buffer as 16 little-endian words, read at one signal address
  logic [31:0] wmem [16];
  logic [31:0] a, b, c, d;
  logic [31:0] h [4];
  logic [COUNT_W-1:0] count;
  logic [5:0]  rnd;
  logic [5:0]  pad_ptr;
  logic        final_blk;   // block being compressed is the length block
  logic        two_pass;    // padding needs an extra block
  logic        last_pend;   // last flag held while the filling block compresses
  logic [1:0]  widx;

  // shared round datapath
  logic [31:0] f, sum, rot, wsel;
  logic [3:0]  g;
  logic [4:0]  s;
  logic [5:0]  rnd1, rnd3, rnd5, rnd7;

  assign rnd1 = rnd * 6'd5 + 6'd1;
  assign rnd3 = rnd * 6'd3 + 6'd5;
  assign rnd7 = rnd * 6'd7;
  assign rnd5 = rnd;

  always_comb begin
    case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd5[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = rnd1[3:0]; end
      2'd2: begin f = b ^ c ^ d;          g = rnd3[3:0]; end
      default: begin f = c ^ (b | ~d);    g = rnd7[3:0]; end
    endcase
    wsel = wmem[g];
    s    = rot_s(rnd);
    sum  = a + f + round_k(rnd) + wsel;
    rot  = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  logic acc;
  assign in_stall = (state != ST_IDLE);
  assign acc = in_valid && !in_stall;

  logic [5:0]  pos;
  logic [5:0]  pad_pos;   // where the 0x80 byte lands on a last transaction
  logic [5:0]  pad_at;    // byte written by the pad sweep this cycle
  logic [63:0] bits;
  assign pos     = count[5:0];
  assign pad_pos = has_byte ? pos + 6'd1 : pos;
  assign pad_at  = pad_ptr + 6'd1;
  assign bits    = {count, 3'b000};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc) begin
        if (has_byte && pos == 6'd63) state_next = ST_ROUND;
        else if (last_byte) state_next = ST_PAD;
      end
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (final_blk) state_next = ST_OUT;
        else if (two_pass || last_pend) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_PAD: if (pad_ptr == 6'd63) state_next = ST_ROUND;
      ST_OUT: if (!out_stall && widx == 2'd3) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      h[0] <= INIT_A; h[1] <= INIT_B; h[2] <= INIT_C; h[3] <= INIT_D;
      rnd <= '0; widx <= '0; final_blk <= 1'b0; two_pass <= 1'b0;
      last_pend <= 1'b0; pad_ptr <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (acc) begin
          last_pend <= last_byte;
          if (has_byte) begin
            count <= count + 1'b1;
            wmem[pos[5:2]][8*pos[1:0] +: 8] <= message_byte;
          end
          if (has_byte && pos == 6'd63) begin
            rnd <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
          end else if (last_byte) begin
            // pad byte goes just after the last message byte
            wmem[pad_pos[5:2]][8*pad_pos[1:0] +: 8] <= PAD_BYTE;
            pad_ptr <= pad_pos;
            two_pass <= (pad_pos >= 6'd56);
          end
        end
        ST_ROUND: begin
          a <= d; d <= c; c <= b;
          b <= b + rot;
          rnd <= rnd + 6'd1;
        end
        ST_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c; h[3] <= h[3] + d;
          widx <= '0;
          if (!final_blk && (two_pass || last_pend)) begin
            // next block starts with the pad byte (full block closed by the
            // last byte) or with zero fill (second block of a two-pass pad)
            wmem[0][7:0] <= two_pass ? 8'h00 : PAD_BYTE;
            pad_ptr <= 6'd0;
            two_pass <= 1'b0;
            last_pend <= 1'b0;
          end
        end
        ST_PAD: begin
          // one byte written per cycle up to 63; length bytes 56..63
          if (pad_ptr != 6'd63) begin
            pad_ptr <= pad_at;
            if (!two_pass && pad_at >= 6'd56)
              wmem[pad_at[5:2]][8*pad_at[1:0] +: 8] <= bits[8*pad_at[2:0] +: 8];
            else
              wmem[pad_at[5:2]][8*pad_at[1:0] +: 8] <= 8'h00;
          end else begin
            rnd <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
            final_blk <= !two_pass;
          end
        end
        ST_OUT: if (!out_stall) begin
          widx <= widx + 2'd1;
          if (widx == 2'd3) begin
            h[0] <= INIT_A; h[1] <= INIT_B; h[2] <= INIT_C; h[3] <= INIT_D;
            count <= '0; final_blk <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = (state == ST_OUT);
  assign digest_word = h[widx];
  assign word_index  = widx;
  assign last_word   = (widx == 2'd3);

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && widx != 2'd3) |=> (out_valid && widx == $past(widx) + 2'd1))
    else $error("digest word order broken");
  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'd63) |=> (state == ST_FOLD))
    else $error("compression did not finish");

endmodule

/* sim/md5_digest_engine_unit_test.sv */
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Drives byte streams through the engine, predicts each digest with a local
// MD5 model and checks the four digest words of every message in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class md5_digest_board;
  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [60:0] nbytes;
  logic [31:0] want_word [$];
  logic [1:0]  want_idx [$];
  logic        want_last [$];
  int          mismatches;

  function void clear_chain();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    nbytes = '0;
  endfunction

  function new();
    clear_chain();
    mismatches = 0;
  endfunction

  function logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, k;
    int g, s;
    int sh [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      // sine table: floor(|sin(i+1)| * 2^32)
      k = 32'(longint'($floor(($sin(i + 1) < 0 ? -$sin(i + 1) : $sin(i + 1)) * 4294967296.0)));
      s = sh[(i / 16) * 4 + i % 4];
      t = d; d = c; c = b;
      b = b + rotl(a + f + k + w[g], s);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  // note an accepted input transaction
  function void note_input(logic hb, logic [7:0] byt, logic lst);
    int rem;
    logic [63:0] bits;
    if (hb) begin
      blk[nbytes[5:0]] = byt;
      nbytes++;
      if (nbytes[5:0] == 0) compress();
    end
    if (!lst) return;
    rem = nbytes[5:0];
    blk[rem] = 8'h80;
    for (int j = rem + 1; j < 64; j++) blk[j] = 8'h00;
    if (rem >= 56) begin
      compress();
      for (int j = 0; j < 56; j++) blk[j] = 8'h00;
    end
    bits = {nbytes, 3'b000};
    for (int j = 0; j < 8; j++) blk[56 + j] = bits[8*j +: 8];
    compress();
    for (int j = 0; j < 4; j++) begin
      want_word.push_back(chain[j]);
      want_idx.push_back(2'(j));
      want_last.push_back(j == 3);
    end
    clear_chain();
  endfunction

  function void check_result(logic [31:0] wd, logic [1:0] ix, logic lw);
    logic [31:0] ew;
    logic [1:0] ei;
    logic el;
    if (want_word.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected digest word %h idx %0d", wd, ix);
      return;
    end
    ew = want_word.pop_front();
    ei = want_idx.pop_front();
    el = want_last.pop_front();
    if (wd !== ew || ix !== ei || lw !== el) begin
      mismatches++;
      if (mismatches <= 10)
        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", ew, ei, el, wd, ix, lw);
    end
  endfunction
endclass

module md5_digest_engine_unit_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        has_byte = 0;
  logic [7:0]  message_byte = 0;
  logic        last_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;
  md5_digest_board board = new();

  md5_digest_engine_unit uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(digest_word, word_index, last_word);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // valid stays up after acceptance; the next send replaces or drops it, a drain drops it
  task automatic send_byte(logic hb, logic [7:0] byt, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    has_byte <= hb;
    message_byte <= byt;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(hb, byt, lst);
  endtask

  task automatic send_message(int len);
    bit empty_end;
    empty_end = (len == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) send_byte(1'b0, 8'($urandom), 1'b0);
      send_byte(1'b1, 8'($urandom), (i == len - 1) && !empty_end);
    end
    if (empty_end) send_byte(1'b0, 8'($urandom), 1'b1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.want_word.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, extreme bytes, ignored empty item, two-byte message
    send_byte(1'b0, 8'h00, 1'b1);
    send_byte(1'b1, 8'h00, 1'b1);
    send_byte(1'b1, 8'hff, 1'b1);
    send_byte(1'b0, 8'hff, 1'b0);
    send_byte(1'b1, 8'h55, 1'b0);
    send_byte(1'b1, 8'haa, 1'b1);
    wait_drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 34 : 0;
      send_message((ph == 0) ? 55 : (ph == 1) ? 56 : 64);
      for (int m = 0; m < 3; m++)
        send_message($urandom_range(0, 9));
    end

    wait_drain();
    if (board.mismatches == 0 && board.want_word.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

/* filelist.f */
hdl/md5_pkg.sv
hdl/md5_digest_engine_unit.sv
sim/md5_digest_engine_unit_test.sv
